// ===== hw/rtl/stlf_pkg.sv =====
// Package for the secure task lifecycle tracker.
// Event codes, status bits, transition codes and doorbell words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stlf_pkg;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned STATE_W = 4;

    localparam int unsigned IN_DATA_W  = 104;
    localparam int unsigned OUT_DATA_W = 112;

    localparam logic [CMD_W-1:0] CMD_PRI_IRQ = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SUBMIT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEC_IRQ = 3'd4;

    localparam logic [WORD_W-1:0] ABORT_BIT = 32'h0004_0000;
    localparam logic [WORD_W-1:0] FATAL_BIT = 32'h0002_0000;
    localparam logic [WORD_W-1:0] DONE_BIT  = 32'h0001_0000;
    localparam logic [WORD_W-1:0] CODE_MASK = 32'h0000_FFFF;

    localparam logic [WORD_W-1:0] CODE_108 = 32'h0000_0108;
    localparam logic [WORD_W-1:0] CODE_107 = 32'h0000_0107;
    localparam logic [WORD_W-1:0] CODE_104 = 32'h0000_0104;
    localparam logic [WORD_W-1:0] CODE_103 = 32'h0000_0103;

    localparam logic [WORD_W-1:0] DB_START   = 32'h0050_0201;
    localparam logic [WORD_W-1:0] DB_RESUME  = 32'h0010_0301;
    localparam logic [WORD_W-1:0] DB_SUSPEND = 32'h0010_0401;

    localparam logic [MODE_W-1:0] MODE_FRESH       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RESUME      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESUME_SUSP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FRESH_ALT   = 3'd4;

endpackage

`default_nettype wire

// ===== hw/rtl/secure_task_lifecycle_fsm_core.sv =====
// Top level of the secure task lifecycle tracker: input register, event
// decode and state update, result register. Depends on stlf_pkg.
//
// Path: an input transfer passes the input register, then the result register,
// before result valid. Throughput: one event per cycle, set by the single
// state update stage; while a result waits the input register takes one more
// event and the input then stalls until the result is taken.
// Reset (i_rst_n low, synchronous) clears task state, mode, result code,
// secondary flag and both stage valids.
`timescale 1ns / 1ps
`default_nettype none

module secure_task_lifecycle_fsm_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [31:0] status_word, [63:32] buffer_word, [66:64] load_mode,
    // [98:67] command_address, [103:99] zero
    input  wire logic [stlf_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // [2:0] cmd
    input  wire logic [2:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [0] rejected, [32:1] ack_value, [33] doorbell_valid,
    // [65:34] doorbell_word, [69:66] task_state_out, [70] task_active_out,
    // [102:71] result_code_out, [103] fatal_seen, [104] secondary_done,
    // [111:105] zero
    output logic [stlf_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    typedef enum logic [stlf_pkg::STATE_W-1:0] {
        ST_NONE       = 4'd0,
        ST_RETIRED    = 4'd1,
        ST_RUNNING    = 4'd2,
        ST_ENDED      = 4'd3,
        ST_STOPPED    = 4'd4,
        ST_EXITED     = 4'd5,
        ST_LOADED     = 4'd6,
        ST_SUSP_ACKED = 4'd7,
        ST_EXIT_WAIT  = 4'd8,
        ST_SUSP_WAIT  = 4'd9,
        ST_COMPLETE   = 4'd10,
        ST_SUSPENDING = 4'd11,
        ST_EXITING    = 4'd12
    } t_task_state;

    logic                             r_in_valid;
    logic [stlf_pkg::CMD_W-1:0]       r_cmd;
    logic [stlf_pkg::WORD_W-1:0]      r_status;
    logic [stlf_pkg::WORD_W-1:0]      r_buf;
    logic [stlf_pkg::MODE_W-1:0]      r_load_mode;
    logic [stlf_pkg::WORD_W-1:0]      r_addr;

    t_task_state                      r_state, n_state;
    logic                             r_active, n_active;
    logic [stlf_pkg::MODE_W-1:0]      r_mode, n_mode;
    logic [stlf_pkg::WORD_W-1:0]      r_result, n_result;
    logic                             r_sec, n_sec;

    logic                             r_out_valid;
    logic                             r_rej, n_rej;
    logic [stlf_pkg::WORD_W-1:0]      r_ack, n_ack;
    logic                             r_dbv, n_dbv;
    logic [stlf_pkg::WORD_W-1:0]      r_dbw, n_dbw;
    logic                             r_fatal, n_fatal;

    logic                             advance;
    logic [stlf_pkg::WORD_W-1:0]      code;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_sec, r_fatal, r_result, r_active,
                              4'(r_state), r_dbw, r_dbv, r_ack, r_rej};

    assign code = (r_status & stlf_pkg::DONE_BIT) != '0 ? stlf_pkg::DONE_BIT
                                                        : (r_status & stlf_pkg::CODE_MASK);

    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_mode   = r_mode;
        n_result = r_result;
        n_sec    = r_sec;
        n_rej    = 1'b0;
        n_ack    = '0;
        n_dbv    = 1'b0;
        n_dbw    = '0;
        n_fatal  = 1'b0;
        case (r_cmd)
            stlf_pkg::CMD_PRI_IRQ: begin
                if ((r_status & stlf_pkg::ABORT_BIT) != '0) begin
                    n_ack = stlf_pkg::ABORT_BIT;
                end else if ((r_status & stlf_pkg::FATAL_BIT) != '0) begin
                    n_ack   = stlf_pkg::FATAL_BIT;
                    n_fatal = 1'b1;
                end else begin
                    n_ack = code;
                    if (r_active) begin
                        case (r_state)
                            ST_EXITING: begin
                                if (code == stlf_pkg::DONE_BIT) begin
                                    n_state  = ST_COMPLETE;
                                    n_result = r_buf;
                                end else if (code == stlf_pkg::CODE_108) begin
                                    n_state = ST_SUSP_WAIT;
                                end else begin
                                    n_state  = ST_ENDED;
                                    n_result = code;
                                end
                            end
                            ST_SUSPENDING: begin
                                if (code == stlf_pkg::DONE_BIT) begin
                                    n_state  = ST_COMPLETE;
                                    n_result = r_buf;
                                end else if (code == stlf_pkg::CODE_107) begin
                                    n_state = ST_SUSP_ACKED;
                                end else begin
                                    n_state  = ST_ENDED;
                                    n_result = code;
                                end
                            end
                            ST_COMPLETE: begin
                                if (code == stlf_pkg::CODE_103) begin
                                    n_state = ST_ENDED;
                                end
                            end
                            ST_SUSP_WAIT: begin
                                if (code == stlf_pkg::CODE_104) begin
                                    n_state = ST_STOPPED;
                                end else begin
                                    n_state  = ST_ENDED;
                                    n_result = code;
                                end
                            end
                            ST_RUNNING: begin
                                if (code == stlf_pkg::DONE_BIT) begin
                                    n_state = ST_ENDED;
                                end else if (code == stlf_pkg::CODE_104) begin
                                    n_state = ST_STOPPED;
                                end
                            end
                            ST_RETIRED, ST_ENDED, ST_STOPPED, ST_EXITED: begin
                                n_active = 1'b0;
                            end
                            ST_SUSP_ACKED: begin
                                if (code == stlf_pkg::CODE_104) begin
                                    n_state = ST_RETIRED;
                                end else begin
                                    n_state  = ST_ENDED;
                                    n_result = code;
                                end
                            end
                            ST_LOADED: begin
                                if (r_mode == stlf_pkg::MODE_RESUME_SUSP) begin
                                    n_mode = stlf_pkg::MODE_FRESH;
                                end
                                if (code == stlf_pkg::DONE_BIT) begin
                                    n_state = ST_COMPLETE;
                                end else if (code == stlf_pkg::CODE_103) begin
                                    n_state = ST_RUNNING;
                                end else begin
                                    n_state  = ST_ENDED;
                                    n_result = code;
                                end
                            end
                            ST_EXIT_WAIT: begin
                                if (code == stlf_pkg::DONE_BIT) begin
                                    n_state  = ST_COMPLETE;
                                    n_result = r_buf;
                                end else if (code == stlf_pkg::CODE_104) begin
                                    n_state = ST_EXITED;
                                end else begin
                                    n_state  = ST_ENDED;
                                    n_result = code;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            stlf_pkg::CMD_LOAD: begin
                if (r_active) begin
                    n_rej = 1'b1;
                end else begin
                    n_state = ST_LOADED;
                    n_mode  = r_load_mode;
                    if (r_load_mode inside {stlf_pkg::MODE_RESUME,
                                            stlf_pkg::MODE_RESUME_SUSP}) begin
                        n_active = 1'b1;
                        n_dbv    = 1'b1;
                        n_dbw    = stlf_pkg::DB_RESUME;
                    end else if (r_load_mode inside {stlf_pkg::MODE_FRESH,
                                                     stlf_pkg::MODE_FRESH_ALT}) begin
                        n_active = 1'b1;
                        n_dbv    = 1'b1;
                        n_dbw    = stlf_pkg::DB_START;
                    end else begin
                        n_rej = 1'b1;
                    end
                end
            end
            stlf_pkg::CMD_SUSPEND: begin
                if (!r_active || r_state != ST_RUNNING) begin
                    n_rej = 1'b1;
                end else begin
                    n_state = ST_SUSPENDING;
                    n_mode  = stlf_pkg::MODE_RESUME_SUSP;
                    n_dbv   = 1'b1;
                    n_dbw   = stlf_pkg::DB_SUSPEND;
                end
            end
            stlf_pkg::CMD_SUBMIT: begin
                if (!r_active || r_state != ST_RUNNING) begin
                    n_rej = 1'b1;
                end else begin
                    n_dbv = 1'b1;
                    n_dbw = r_addr | 32'd1;
                end
            end
            stlf_pkg::CMD_SEC_IRQ: begin
                n_ack = r_status;
                if (r_active) begin
                    n_sec = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_NONE;
            r_active    <= 1'b0;
            r_mode      <= '0;
            r_result    <= '0;
            r_sec       <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (advance && r_in_valid) begin
                r_state  <= n_state;
                r_active <= n_active;
                r_mode   <= n_mode;
                r_result <= n_result;
                r_sec    <= n_sec;
            end
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_cmd       <= i_s_axis_tuser;
            r_status    <= i_s_axis_tdata[31:0];
            r_buf       <= i_s_axis_tdata[63:32];
            r_load_mode <= i_s_axis_tdata[66:64];
            r_addr      <= i_s_axis_tdata[98:67];
        end
        if (advance && r_in_valid) begin
            r_rej   <= n_rej;
            r_ack   <= n_ack;
            r_dbv   <= n_dbv;
            r_dbw   <= n_dbw;
            r_fatal <= n_fatal;
        end
    end

    a_doorbell_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_dbv |-> !r_rej)
        else $error("doorbell issued on a rejected request");

    a_no_doorbell_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_dbv |-> r_dbw == '0)
        else $error("doorbell word without doorbell valid");

    a_fatal_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_fatal |-> r_ack == stlf_pkg::FATAL_BIT)
        else $error("fatal flag without fatal acknowledge");

    a_active_not_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_state != ST_NONE)
        else $error("active task in the empty state");

    a_stalled_input_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_cmd) && $stable(r_status))
        else $error("held event lost while result stage stalled");

endmodule

`default_nettype wire
